[hw/rtl/e13_pkg.sv]
package e13_pkg;

    localparam int unsigned NUM_DIGITS   = 12;
    localparam int unsigned NUM_SEGMENTS = 17;

    localparam logic [2:0] KIND_QUIET = 3'd0;
    localparam logic [2:0] KIND_GUARD = 3'd1;
    localparam logic [2:0] KIND_LEFT  = 3'd2;
    localparam logic [2:0] KIND_SEP   = 3'd3;
    localparam logic [2:0] KIND_RIGHT = 3'd4;

    localparam logic [8:0] MODS_QUIET = 9'h000;
    localparam logic [8:0] MODS_GUARD = 9'h005;
    localparam logic [8:0] MODS_SEP   = 9'h00A;

    localparam logic [3:0] CNT_QUIET = 4'd9;
    localparam logic [3:0] CNT_GUARD = 4'd3;
    localparam logic [3:0] CNT_DIGIT = 4'd7;
    localparam logic [3:0] CNT_SEP   = 4'd5;

    // segment positions
    localparam logic [4:0] SEG_QUIET_HEAD = 5'd0;
    localparam logic [4:0] SEG_GUARD_HEAD = 5'd1;
    localparam logic [4:0] SEG_LEFT_LO    = 5'd2;
    localparam logic [4:0] SEG_LEFT_HI    = 5'd7;
    localparam logic [4:0] SEG_SEP        = 5'd8;
    localparam logic [4:0] SEG_RIGHT_LO   = 5'd9;
    localparam logic [4:0] SEG_CHECK      = 5'd14;
    localparam logic [4:0] SEG_GUARD_TAIL = 5'd15;
    localparam logic [4:0] SEG_QUIET_TAIL = 5'd16;

    typedef logic [NUM_DIGITS-1:0][3:0] t_digits;

    typedef struct packed {
        t_digits    digits;
        logic [3:0] check;
        logic [5:0] parity;
    } t_code_item;

    function automatic logic [3:0] clamp_digit(input logic [3:0] nib);
        clamp_digit = (nib > 4'd9) ? 4'd0 : nib;
    endfunction

    function automatic logic [6:0] code_l(input logic [3:0] d);
        case (d)
            4'd0:    code_l = 7'h0D;
            4'd1:    code_l = 7'h19;
            4'd2:    code_l = 7'h13;
            4'd3:    code_l = 7'h3D;
            4'd4:    code_l = 7'h23;
            4'd5:    code_l = 7'h31;
            4'd6:    code_l = 7'h2F;
            4'd7:    code_l = 7'h3B;
            4'd8:    code_l = 7'h37;
            4'd9:    code_l = 7'h0B;
            default: code_l = 7'h0D;
        endcase
    endfunction

    function automatic logic [6:0] code_g(input logic [3:0] d);
        case (d)
            4'd0:    code_g = 7'h27;
            4'd1:    code_g = 7'h33;
            4'd2:    code_g = 7'h1B;
            4'd3:    code_g = 7'h21;
            4'd4:    code_g = 7'h1D;
            4'd5:    code_g = 7'h39;
            4'd6:    code_g = 7'h05;
            4'd7:    code_g = 7'h11;
            4'd8:    code_g = 7'h09;
            4'd9:    code_g = 7'h17;
            default: code_g = 7'h27;
        endcase
    endfunction

    // bit 5 goes with the first left digit, 1 selects g code
    function automatic logic [5:0] parity_sel(input logic [3:0] d);
        case (d)
            4'd0:    parity_sel = 6'h00;
            4'd1:    parity_sel = 6'h0B;
            4'd2:    parity_sel = 6'h0D;
            4'd3:    parity_sel = 6'h0E;
            4'd4:    parity_sel = 6'h13;
            4'd5:    parity_sel = 6'h19;
            4'd6:    parity_sel = 6'h1C;
            4'd7:    parity_sel = 6'h15;
            4'd8:    parity_sel = 6'h16;
            4'd9:    parity_sel = 6'h1A;
            default: parity_sel = 6'h00;
        endcase
    endfunction

endpackage

[hw/rtl/e13_check.sv]
module e13_check (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [47:0]         i_digits_bcd,
    output logic                o_item_valid,
    input  logic                i_item_ready,
    output e13_pkg::t_code_item o_item
);

    logic             r_s1_valid;
    e13_pkg::t_digits r_s1_digits;
    logic [7:0]       r_s1_sum;
    logic             r_s2_valid;
    e13_pkg::t_code_item r_s2_item;

    e13_pkg::t_digits n_s1_digits;
    logic [7:0]       n_s1_sum;
    logic [15:0]      n_prod;
    logic [4:0]       n_quot;
    logic [7:0]       n_rem;
    logic [3:0]       n_check;
    logic             s1_ready;
    logic             s2_ready;

    assign s2_ready = !r_s2_valid || i_item_ready;
    assign s1_ready = !r_s1_valid || s2_ready;
    assign o_stall  = !s1_ready;

    // stage 1: clamp nibbles and form the 1/3 weighted sum
    always_comb begin
        n_s1_sum = 8'd0;
        for (int k = 0; k < e13_pkg::NUM_DIGITS; k++) begin
            n_s1_digits[k] = e13_pkg::clamp_digit(i_digits_bcd[47 - 4*k -: 4]);
        end
        for (int p = 0; p < e13_pkg::NUM_DIGITS / 2; p++) begin
            n_s1_sum = n_s1_sum + {4'd0, n_s1_digits[2*p]}
                     + {3'd0, n_s1_digits[2*p+1], 1'b0} + {4'd0, n_s1_digits[2*p+1]};
        end
    end

    // stage 2: sum mod 10 via reciprocal, sum never exceeds 216
    always_comb begin
        n_prod  = {8'd0, r_s1_sum} * 16'd205;
        n_quot  = n_prod[15:11];
        n_rem   = r_s1_sum - ({3'd0, n_quot} * 8'd10);
        n_check = (n_rem[3:0] == 4'd0) ? 4'd0 : (4'd10 - n_rem[3:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (s1_ready) begin
                r_s1_valid <= i_valid;
            end
            if (s2_ready) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready && i_valid) begin
            r_s1_digits <= n_s1_digits;
            r_s1_sum    <= n_s1_sum;
        end
        if (s2_ready && r_s1_valid) begin
            r_s2_item.digits <= r_s1_digits;
            r_s2_item.check  <= n_check;
            r_s2_item.parity <= e13_pkg::parity_sel(r_s1_digits[0]);
        end
    end

    assign o_item_valid = r_s2_valid;
    assign o_item       = r_s2_item;

endmodule

[hw/rtl/e13_segmenter.sv]
module e13_segmenter (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_item_valid,
    output logic                o_item_ready,
    input  e13_pkg::t_code_item i_item,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [8:0]          o_modules,
    output logic [3:0]          o_module_count,
    output logic [2:0]          o_segment_kind,
    output logic                o_full_height,
    output logic [3:0]          o_check_value,
    output logic                o_last_segment
);

    logic                r_busy;
    logic [4:0]          r_idx;
    e13_pkg::t_code_item r_item;

    logic       r_o_valid;
    logic [8:0] r_modules;
    logic [3:0] r_module_count;
    logic [2:0] r_segment_kind;
    logic       r_full_height;
    logic [3:0] r_check_value;
    logic       r_last_segment;

    logic       out_load;
    logic       emit;
    logic       seg_last;
    logic [3:0] dsel;
    logic [3:0] dval;
    logic [2:0] pbit;
    logic [8:0] n_modules;
    logic [3:0] n_module_count;
    logic [2:0] n_segment_kind;
    logic       n_full_height;

    assign out_load     = !r_o_valid || !i_stall;
    assign emit         = r_busy && out_load;
    assign seg_last     = (r_idx == e13_pkg::SEG_QUIET_TAIL);
    assign o_item_ready = !r_busy || (emit && seg_last);

    // one digit read per segment: left digits 1..6, right digits 7..11
    always_comb begin
        dsel = (r_idx <= e13_pkg::SEG_LEFT_HI) ? 4'(r_idx - 5'd1) : 4'(r_idx - 5'd2);
        dval = (r_idx == e13_pkg::SEG_CHECK) ? r_item.check : r_item.digits[dsel];
        pbit = 3'(5'd7 - r_idx);
    end

    always_comb begin
        n_modules      = e13_pkg::MODS_QUIET;
        n_module_count = e13_pkg::CNT_QUIET;
        n_segment_kind = e13_pkg::KIND_QUIET;
        n_full_height  = 1'b0;
        case (r_idx) inside
            e13_pkg::SEG_QUIET_HEAD, e13_pkg::SEG_QUIET_TAIL: begin
                n_modules      = e13_pkg::MODS_QUIET;
                n_module_count = e13_pkg::CNT_QUIET;
                n_segment_kind = e13_pkg::KIND_QUIET;
            end
            e13_pkg::SEG_GUARD_HEAD, e13_pkg::SEG_GUARD_TAIL: begin
                n_modules      = e13_pkg::MODS_GUARD;
                n_module_count = e13_pkg::CNT_GUARD;
                n_segment_kind = e13_pkg::KIND_GUARD;
                n_full_height  = 1'b1;
            end
            [e13_pkg::SEG_LEFT_LO:e13_pkg::SEG_LEFT_HI]: begin
                n_modules      = {2'b00, r_item.parity[pbit] ? e13_pkg::code_g(dval)
                                                             : e13_pkg::code_l(dval)};
                n_module_count = e13_pkg::CNT_DIGIT;
                n_segment_kind = e13_pkg::KIND_LEFT;
            end
            e13_pkg::SEG_SEP: begin
                n_modules      = e13_pkg::MODS_SEP;
                n_module_count = e13_pkg::CNT_SEP;
                n_segment_kind = e13_pkg::KIND_SEP;
                n_full_height  = 1'b1;
            end
            [e13_pkg::SEG_RIGHT_LO:e13_pkg::SEG_CHECK]: begin
                n_modules      = {2'b00, ~e13_pkg::code_l(dval)};
                n_module_count = e13_pkg::CNT_DIGIT;
                n_segment_kind = e13_pkg::KIND_RIGHT;
            end
            default: begin
                n_modules      = e13_pkg::MODS_QUIET;
                n_module_count = e13_pkg::CNT_QUIET;
                n_segment_kind = e13_pkg::KIND_QUIET;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_idx     <= 5'd0;
            r_o_valid <= 1'b0;
        end else begin
            if (o_item_ready) begin
                r_busy <= i_item_valid;
                r_idx  <= 5'd0;
            end else if (emit) begin
                r_idx <= r_idx + 5'd1;
            end
            if (out_load) begin
                r_o_valid <= r_busy;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_item_ready && i_item_valid) begin
            r_item <= i_item;
        end
        if (emit) begin
            r_modules      <= n_modules;
            r_module_count <= n_module_count;
            r_segment_kind <= n_segment_kind;
            r_full_height  <= n_full_height;
            r_check_value  <= r_item.check;
            r_last_segment <= seg_last;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_modules      = r_modules;
    assign o_module_count = r_module_count;
    assign o_segment_kind = r_segment_kind;
    assign o_full_height  = r_full_height;
    assign o_check_value  = r_check_value;
    assign o_last_segment = r_last_segment;

endmodule

[hw/rtl/ean13_barcode_encoder_top.sv]
// a code passes check stages 1 and 2, then the segmenter's item and output registers
// throughput: one segment per cycle while i_stall is low, out of the single segment port
// the next code is taken while the previous symbol's segments still drain
// reset: synchronous active-low i_rst_n clears all valid bits and the segment counter
module ean13_barcode_encoder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [47:0] i_digits_bcd,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [8:0]  o_modules,
    output logic [3:0]  o_module_count,
    output logic [2:0]  o_segment_kind,
    output logic        o_full_height,
    output logic [3:0]  o_check_value,
    output logic        o_last_segment
);

    logic                item_valid;
    logic                item_ready;
    e13_pkg::t_code_item item;

    e13_check u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_digits_bcd (i_digits_bcd),
        .o_item_valid (item_valid),
        .i_item_ready (item_ready),
        .o_item       (item)
    );

    e13_segmenter u_segmenter (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item_valid   (item_valid),
        .o_item_ready   (item_ready),
        .i_item         (item),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_modules      (o_modules),
        .o_module_count (o_module_count),
        .o_segment_kind (o_segment_kind),
        .o_full_height  (o_full_height),
        .o_check_value  (o_check_value),
        .o_last_segment (o_last_segment)
    );

endmodule

[test/ean13_checker.sv]
module ean13_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_code_valid,
    input  logic        i_code_stall,
    input  logic [47:0] i_digits_bcd,
    input  logic        i_seg_valid,
    input  logic        i_seg_stall,
    input  logic [8:0]  i_modules,
    input  logic [3:0]  i_module_count,
    input  logic [2:0]  i_segment_kind,
    input  logic        i_full_height,
    input  logic [3:0]  i_check_value,
    input  logic        i_last_segment,
    output int          o_mismatches,
    output int          o_segs_pending
);

    // digit 9 sits leftmost, digit 0 rightmost
    localparam logic [9:0][6:0] L_SET = {7'h0B, 7'h37, 7'h3B, 7'h2F, 7'h31,
                                         7'h23, 7'h3D, 7'h13, 7'h19, 7'h0D};
    localparam logic [9:0][6:0] G_SET = {7'h17, 7'h09, 7'h11, 7'h05, 7'h39,
                                         7'h1D, 7'h21, 7'h1B, 7'h33, 7'h27};
    localparam logic [9:0][5:0] PARITY_SET = {6'h1A, 6'h16, 6'h15, 6'h1C, 6'h19,
                                              6'h13, 6'h0E, 6'h0D, 6'h0B, 6'h00};

    typedef struct packed {
        logic [15:0] code_no;
        logic [4:0]  seg_no;
        logic [8:0]  modules;
        logic [3:0]  module_count;
        logic [2:0]  kind;
        logic        full_height;
        logic [3:0]  check;
        logic        last;
    } t_segment;

    t_segment expected_segs[$];
    t_segment want;
    int       mismatch_total = 0;
    int       codes_seen = 0;

    task automatic report_mismatch(input string what);
        $display("checker: %s", what);
        mismatch_total++;
    endtask

    task automatic compare_field(input string name, input int got, input int exp_val);
        if (got != exp_val)
            report_mismatch($sformatf("code %0d segment %0d: %s is %0h, should be %0h",
                                      want.code_no, want.seg_no, name, got, exp_val));
    endtask

    task automatic predict_symbol(input logic [47:0] code);
        logic [3:0] digit [12];
        logic [3:0] nib;
        logic [3:0] check_digit;
        logic [3:0] d;
        logic [5:0] parity;
        int         sum;
        int         pos;
        t_segment   seg;
        sum = 0;
        for (int k = 0; k < 12; k++) begin
            nib = code[47 - 4*k -: 4];
            // nibbles above nine read as zero
            digit[k] = (nib > 4'd9) ? 4'd0 : nib;
            sum += (k % 2 == 1) ? 3 * digit[k] : digit[k];
        end
        check_digit = 4'((10 - sum % 10) % 10);
        parity = PARITY_SET[digit[0]];
        for (int s = 0; s < e13_pkg::NUM_SEGMENTS; s++) begin
            seg.code_no = 16'(codes_seen);
            seg.seg_no  = 5'(s);
            seg.check   = check_digit;
            seg.last    = (s == e13_pkg::NUM_SEGMENTS - 1);
            if (s == e13_pkg::SEG_QUIET_HEAD || s == e13_pkg::SEG_QUIET_TAIL) begin
                seg.modules = e13_pkg::MODS_QUIET;
                seg.module_count = e13_pkg::CNT_QUIET;
                seg.kind = e13_pkg::KIND_QUIET;
                seg.full_height = 1'b0;
            end else if (s == e13_pkg::SEG_GUARD_HEAD || s == e13_pkg::SEG_GUARD_TAIL) begin
                seg.modules = e13_pkg::MODS_GUARD;
                seg.module_count = e13_pkg::CNT_GUARD;
                seg.kind = e13_pkg::KIND_GUARD;
                seg.full_height = 1'b1;
            end else if (s <= e13_pkg::SEG_LEFT_HI) begin
                pos = s - e13_pkg::SEG_LEFT_LO;
                d = digit[pos + 1];
                seg.modules = {2'b00, parity[5 - pos] ? G_SET[d] : L_SET[d]};
                seg.module_count = e13_pkg::CNT_DIGIT;
                seg.kind = e13_pkg::KIND_LEFT;
                seg.full_height = 1'b0;
            end else if (s == e13_pkg::SEG_SEP) begin
                seg.modules = e13_pkg::MODS_SEP;
                seg.module_count = e13_pkg::CNT_SEP;
                seg.kind = e13_pkg::KIND_SEP;
                seg.full_height = 1'b1;
            end else begin
                pos = s - e13_pkg::SEG_RIGHT_LO;
                d = (s == e13_pkg::SEG_CHECK) ? check_digit : digit[pos + 7];
                // right-hand code is the bitwise inverse of the left odd set
                seg.modules = {2'b00, ~L_SET[d]};
                seg.module_count = e13_pkg::CNT_DIGIT;
                seg.kind = e13_pkg::KIND_RIGHT;
                seg.full_height = 1'b0;
            end
            expected_segs.push_back(seg);
        end
        codes_seen++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_seg_valid && !i_seg_stall) begin
                if (expected_segs.size() == 0) begin
                    report_mismatch("segment transfer with no code outstanding");
                end else begin
                    want = expected_segs.pop_front();
                    compare_field("modules", i_modules, want.modules);
                    compare_field("module_count", i_module_count, want.module_count);
                    compare_field("segment_kind", i_segment_kind, want.kind);
                    compare_field("full_height", i_full_height, want.full_height);
                    compare_field("check_value", i_check_value, want.check);
                    compare_field("last_segment", i_last_segment, want.last);
                end
            end
            if (i_code_valid && !i_code_stall)
                predict_symbol(i_digits_bcd);
        end
        o_mismatches   <= mismatch_total;
        o_segs_pending <= expected_segs.size();
    end

endmodule

[test/testbench.sv]
module testbench;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_CODES = 146;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        code_valid = 1'b0;
    logic [47:0] code_digits = '0;
    logic        seg_stall = 1'b0;
    logic        code_stall;
    logic        seg_valid;
    logic [8:0]  seg_modules;
    logic [3:0]  seg_count;
    logic [2:0]  seg_kind;
    logic        seg_full;
    logic [3:0]  seg_check;
    logic        seg_last;
    int          mismatches;
    int          segs_pending;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_asked = 0;
    int hold_served = 0;
    int hold_left = 0;
    int cycle_count = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    ean13_barcode_encoder_top uut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_valid        (code_valid),
        .o_stall        (code_stall),
        .i_digits_bcd   (code_digits),
        .o_valid        (seg_valid),
        .i_stall        (seg_stall),
        .o_modules      (seg_modules),
        .o_module_count (seg_count),
        .o_segment_kind (seg_kind),
        .o_full_height  (seg_full),
        .o_check_value  (seg_check),
        .o_last_segment (seg_last)
    );

    ean13_checker symbol_check (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_code_valid   (code_valid),
        .i_code_stall   (code_stall),
        .i_digits_bcd   (code_digits),
        .i_seg_valid    (seg_valid),
        .i_seg_stall    (seg_stall),
        .i_modules      (seg_modules),
        .i_module_count (seg_count),
        .i_segment_kind (seg_kind),
        .i_full_height  (seg_full),
        .i_check_value  (seg_check),
        .i_last_segment (seg_last),
        .o_mismatches   (mismatches),
        .o_segs_pending (segs_pending)
    );

    // receiver side: random stall, or a long hold-off when one is asked for
    always @(negedge clk) begin
        if (hold_left > 0) begin
            seg_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_served != hold_asked) begin
            seg_stall <= 1'b1;
            hold_left <= HOLD_CYCLES;
            hold_served <= hold_asked;
        end else begin
            seg_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // mostly decimal digits, some nibbles above nine, now and then raw bits
    function automatic logic [47:0] random_code();
        logic [47:0] c;
        if ($urandom_range(9) == 0) begin
            c[31:0]  = $urandom();
            c[47:32] = 16'($urandom());
        end else begin
            for (int k = 0; k < 12; k++)
                c[4*k +: 4] = ($urandom_range(7) == 0) ? 4'($urandom_range(15))
                                                       : 4'($urandom_range(9));
        end
        return c;
    endfunction

    // returns at a falling edge right after the transfer
    task automatic send_code(input logic [47:0] code);
        while ($urandom_range(99) < send_idle_pct) begin
            code_valid <= 1'b0;
            @(negedge clk);
        end
        code_valid  <= 1'b1;
        code_digits <= code;
        @(posedge clk);
        while (code_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    initial begin
        logic [3:0] dn;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 25;
                    recv_idle_pct = 85;
                end
                1: begin
                    send_idle_pct = 85;
                    recv_idle_pct = 25;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    // receiver holds off while codes keep coming
                    hold_asked++;
                end
            endcase

            if (phase == 0) begin
                for (int d = 0; d < 10; d++) begin
                    dn = 4'(d);
                    send_code({12{dn}});
                end
                // every first digit picks its own left-hand parity
                for (int d = 1; d < 10; d++) begin
                    dn = 4'(d);
                    send_code({dn, 44'h01234567890});
                end
                send_code(48'hFFFF_FFFF_FFFF);
                send_code(48'hABCD_EFAB_CDEF);
                send_code(48'h1F2E_3D4C_5B6A);
            end

            for (int n = 0; n < RANDOM_CODES; n++) begin
                if (phase == 2 && n == RANDOM_CODES / 2)
                    hold_asked++;
                send_code(random_code());
            end
            code_valid <= 1'b0;
            wait (segs_pending == 0);
            @(negedge clk);
        end

        repeat (30) @(posedge clk);
        if (mismatches == 0 && segs_pending == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
